/* hdl/ehash_pkg.sv */
// Shared types and constants for the extendible hash table.
// No dependencies.
package ehash_pkg;

  localparam int DEF_MAX_DEPTH    = 8;
  localparam int DEF_MAX_CAPACITY = 8;
  localparam int DEF_KEY_BITS     = 32;

  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 4;
  localparam int BUSED_W  = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DEPTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = 4'd1;

  localparam logic [CFG_DATA_W-1:0] RST_INITIAL_DEPTH   = 4'd1;
  localparam logic [CFG_DATA_W-1:0] RST_BUCKET_CAPACITY = 4'd4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEL_MISS = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

endpackage

/* hdl/ehash_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ehash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ehash_queue.sv */
// Two-entry word queue between the front and the back of the hash table.
// No dependencies.
module ehash_queue #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] entry [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign head  = entry[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/ehash_front.sv */
// Front end: accepts words, classifies the command and masks the key.
// Depends on ehash_pkg.
module ehash_front #(
  parameter int KW = 32
) (
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [ehash_pkg::CMD_W-1:0]  cmd,
  input  logic [ehash_pkg::KEY_W-1:0]  key,
  input  logic                         q_full,
  input  logic                         clearing,
  output logic                         push,
  output logic [KW+1:0]                push_data
);
  import ehash_pkg::*;

  op_t op;

  always_comb begin
    case (cmd)
      CMD_INSERT: op = OP_INSERT;
      CMD_DELETE: op = OP_DELETE;
      default:    op = OP_SEARCH;
    endcase
  end

  assign item_stall = q_full | clearing;
  assign push       = item_valid & ~item_stall;
  assign push_data  = {op, key[KW-1:0]};

endmodule

/* hdl/ehash_back.sv */
// Back end: sequencer that carries out insert, search, delete and splits.
// Depends on ehash_pkg and ehash_ram.
module ehash_back #(
  parameter int MAX_DEPTH    = 8,
  parameter int MAX_CAPACITY = 8,
  parameter int KW           = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [ehash_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ehash_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [KW+1:0]                    q_head,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [ehash_pkg::STATUS_W-1:0]   status,
  output logic [ehash_pkg::DEPTH_W-1:0]    depth_now,
  output logic [ehash_pkg::BUSED_W-1:0]    buckets_used
);
  import ehash_pkg::*;

  localparam int MD   = MAX_DEPTH;
  localparam int POOL = 1 << MD;
  localparam int DW   = $clog2(MAX_DEPTH + 1);
  localparam int CW   = $clog2(MAX_CAPACITY + 1);
  localparam int SW   = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int KAW  = MD + SW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIR_RD, S_BKT_RD, S_BKT_WAIT, S_SCAN_RD, S_SCAN_CHK,
    S_SHIFT_RD, S_SHIFT_WR, S_DEL_FIN, S_DBL_RD, S_DBL_WR, S_SPLIT, S_SPLIT2,
    S_RDIR_RD, S_RDIR_CHK, S_RKEY_RD, S_RKEY_WR, S_RFILL1, S_RFILL2, S_DONE
  } state_t;

  state_t            state;
  logic [CFG_DATA_W-1:0] init_depth;
  logic [CFG_DATA_W-1:0] capacity;
  op_t               op;
  logic [KW-1:0]     key_r;
  logic [MD-1:0]     b;
  logic [MD-1:0]     nb;
  logic [DW-1:0]     l;
  logic [DW-1:0]     g;
  logic [CW-1:0]     f;
  logic [CW-1:0]     ki;
  logic [CW-1:0]     keep;
  logic [CW-1:0]     ncnt;
  logic [MD-1:0]     si;
  logic [MD:0]       nfb;
  logic [STATUS_W-1:0] st;

  logic [DW-1:0]     eff_d;
  logic [CW-1:0]     eff_cap;
  logic [MD-1:0]     gmask;
  logic [31:0]       key_ext;
  logic [31:0]       si_ext;
  logic [31:0]       rkey_ext;
  logic [31:0]       nfb_ext;
  logic [CW-1:0]     ki_inc;

  logic              dir_we, ld_we, fill_we, key_we;
  logic [MD-1:0]     dir_waddr, dir_raddr, dir_wdata, dir_rdata;
  logic [MD-1:0]     ld_waddr, ld_raddr, fill_waddr, fill_raddr;
  logic [DW-1:0]     ld_wdata, ld_rdata;
  logic [CW-1:0]     fill_wdata, fill_rdata;
  logic [KAW-1:0]    key_waddr, key_raddr;
  logic [KW-1:0]     key_wdata, key_rdata;

  ehash_ram #(.WIDTH(MD), .DEPTH(POOL)) u_dir (
    .clk, .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );
  ehash_ram #(.WIDTH(DW), .DEPTH(POOL)) u_ld (
    .clk, .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
    .raddr(ld_raddr), .rdata(ld_rdata)
  );
  ehash_ram #(.WIDTH(CW), .DEPTH(POOL)) u_fill (
    .clk, .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );
  ehash_ram #(.WIDTH(KW), .DEPTH(POOL << SW)) u_keys (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  assign eff_d = (init_depth > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(init_depth);
  assign eff_cap = (capacity == '0) ? CW'(1) :
                   (capacity > MAX_CAPACITY) ? CW'(MAX_CAPACITY) : CW'(capacity);
  assign gmask    = MD'((32'd1 << g) - 32'd1);
  assign key_ext  = 32'(key_r);
  assign si_ext   = 32'(si);
  assign rkey_ext = 32'(key_rdata);
  assign nfb_ext  = 32'(nfb);
  assign ki_inc   = ki + 1'b1;

  assign clearing     = (state == S_CLEAR);
  assign q_pop        = (state == S_IDLE) & ~q_empty;

  function automatic logic f_fits();
    return fill_rdata < eff_cap;
  endfunction

  always_comb begin
    dir_we = 1'b0; dir_waddr = si; dir_wdata = si;
    dir_raddr = key_ext[MD-1:0] & gmask;
    ld_we = 1'b0; ld_waddr = si; ld_wdata = eff_d; ld_raddr = dir_rdata;
    fill_we = 1'b0; fill_waddr = si; fill_wdata = '0; fill_raddr = dir_rdata;
    key_we = 1'b0; key_waddr = {b, f[SW-1:0]}; key_wdata = key_r;
    key_raddr = {b, ki[SW-1:0]};
    case (state)
      S_CLEAR: begin
        dir_we = 1'b1; ld_we = 1'b1; fill_we = 1'b1;
      end
      S_BKT_WAIT: begin
        if (op == OP_INSERT && f_fits()) begin
          key_we = 1'b1;
          fill_we = 1'b1; fill_waddr = b; fill_wdata = fill_rdata + 1'b1;
          key_waddr = {b, fill_rdata[SW-1:0]};
        end
      end
      S_SHIFT_RD: key_raddr = {b, ki_inc[SW-1:0]};
      S_SHIFT_WR: begin
        key_we = 1'b1; key_waddr = {b, ki[SW-1:0]}; key_wdata = key_rdata;
      end
      S_DEL_FIN: begin
        fill_we = 1'b1; fill_waddr = b; fill_wdata = f - 1'b1;
      end
      S_DBL_RD: dir_raddr = si;
      S_DBL_WR: begin
        dir_we = 1'b1; dir_waddr = MD'((32'd1 << g) + si_ext); dir_wdata = dir_rdata;
      end
      S_SPLIT: begin
        ld_we = 1'b1; ld_waddr = b; ld_wdata = l + 1'b1;
      end
      S_SPLIT2: begin
        ld_we = 1'b1; ld_waddr = nb; ld_wdata = l + 1'b1;
      end
      S_RDIR_RD: dir_raddr = si;
      S_RDIR_CHK: begin
        dir_we = (dir_rdata == b) & si_ext[l]; dir_wdata = nb;
      end
      S_RKEY_WR: begin
        key_we = 1'b1;
        if (rkey_ext[l]) key_waddr = {nb, ncnt[SW-1:0]};
        else key_waddr = {b, keep[SW-1:0]};
        key_wdata = key_rdata;
      end
      S_RFILL1: begin
        fill_we = 1'b1; fill_waddr = b; fill_wdata = keep;
      end
      S_RFILL2: begin
        fill_we = 1'b1; fill_waddr = nb; fill_wdata = ncnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      si           <= '0;
      init_depth   <= RST_INITIAL_DEPTH;
      capacity     <= RST_BUCKET_CAPACITY;
      result_valid <= 1'b0;
      g            <= '0;
      nfb          <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;
      if (cfg_valid && (cfg_index == REG_INITIAL_DEPTH ||
                        cfg_index == REG_BUCKET_CAPACITY)) begin
        if (cfg_index == REG_INITIAL_DEPTH) init_depth <= cfg_data;
        else capacity <= cfg_data;
        state <= S_CLEAR;
        si    <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            si <= si + 1'b1;
            if (si == MD'(POOL - 1)) begin
              g     <= eff_d;
              nfb   <= (MD+1)'(32'd1 << eff_d);
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (!q_empty) begin
              op    <= op_t'(q_head[KW+1:KW]);
              key_r <= q_head[KW-1:0];
              state <= S_DIR_RD;
            end
          end
          S_DIR_RD: state <= S_BKT_RD;
          S_BKT_RD: begin
            b     <= dir_rdata;
            state <= S_BKT_WAIT;
          end
          S_BKT_WAIT: begin
            l  <= ld_rdata;
            f  <= fill_rdata;
            ki <= '0;
            si <= '0;
            if (op != OP_INSERT) begin
              if (fill_rdata == '0) begin
                st    <= (op == OP_DELETE) ? ST_DEL_MISS : ST_ABSENT;
                state <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end else if (f_fits()) begin
              st    <= ST_INSERTED;
              state <= S_DONE;
            end else if (nfb[MD]) begin
              st    <= ST_FULL;
              state <= S_DONE;
            end else if (ld_rdata >= g) begin
              if (g == DW'(MAX_DEPTH)) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else begin
                state <= S_DBL_RD;
              end
            end else begin
              state <= S_SPLIT;
            end
          end
          S_SCAN_RD: state <= S_SCAN_CHK;
          S_SCAN_CHK: begin
            if (key_rdata == key_r) begin
              if (op == OP_SEARCH) begin
                st    <= ST_FOUND;
                state <= S_DONE;
              end else if (ki_inc < f) begin
                state <= S_SHIFT_RD;
              end else begin
                state <= S_DEL_FIN;
              end
            end else begin
              ki <= ki_inc;
              if (ki_inc == f) begin
                st    <= (op == OP_DELETE) ? ST_DEL_MISS : ST_ABSENT;
                state <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end
          end
          S_SHIFT_RD: state <= S_SHIFT_WR;
          S_SHIFT_WR: begin
            ki <= ki_inc;
            if (CW'(ki_inc + 1'b1) < f) state <= S_SHIFT_RD;
            else state <= S_DEL_FIN;
          end
          S_DEL_FIN: begin
            st    <= ST_DELETED;
            state <= S_DONE;
          end
          S_DBL_RD: state <= S_DBL_WR;
          S_DBL_WR: begin
            si <= si + 1'b1;
            if (si == gmask) begin
              g     <= g + 1'b1;
              state <= S_SPLIT;
            end else begin
              state <= S_DBL_RD;
            end
          end
          S_SPLIT: begin
            nb    <= nfb[MD-1:0];
            nfb   <= nfb + 1'b1;
            state <= S_SPLIT2;
          end
          S_SPLIT2: begin
            si    <= '0;
            state <= S_RDIR_RD;
          end
          S_RDIR_RD: state <= S_RDIR_CHK;
          S_RDIR_CHK: begin
            si <= si + 1'b1;
            if (si == gmask) begin
              ki    <= '0;
              keep  <= '0;
              ncnt  <= '0;
              state <= S_RKEY_RD;
            end else begin
              state <= S_RDIR_RD;
            end
          end
          S_RKEY_RD: state <= S_RKEY_WR;
          S_RKEY_WR: begin
            if (rkey_ext[l]) ncnt <= ncnt + 1'b1;
            else keep <= keep + 1'b1;
            ki <= ki_inc;
            if (ki_inc == f) state <= S_RFILL1;
            else state <= S_RKEY_RD;
          end
          S_RFILL1: state <= S_RFILL2;
          S_RFILL2: state <= S_DIR_RD;
          S_DONE: begin
            if (!result_valid || !result_stall) begin
              result_valid <= 1'b1;
              status       <= st;
              depth_now    <= DEPTH_W'(g);
              buckets_used <= nfb_ext[BUSED_W-1:0];
              state        <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

/* hdl/extendible_hash_table.sv */
// Extendible hash table: an item reads the directory and its bucket, scans the bucket
// keys and, for a delete, shifts later keys down. A split rewrites directory slots and
// redistributes the bucket keys; doubling copies each slot of the old directory. One
// item in the back end at a time; a two-word queue decouples the front. Reset, and a
// write to the initial-depth or bucket-capacity register, starts a sweep over all
// 2^MAX_DEPTH slots that rebuilds the directory and bucket tables; items held off.
module extendible_hash_table #(
  parameter int MAX_DEPTH    = ehash_pkg::DEF_MAX_DEPTH,
  parameter int MAX_CAPACITY = ehash_pkg::DEF_MAX_CAPACITY,
  parameter int KEY_BITS     = ehash_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [ehash_pkg::CMD_W-1:0]      cmd,
  input  logic [ehash_pkg::KEY_W-1:0]      key,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [ehash_pkg::STATUS_W-1:0]   status,
  output logic [ehash_pkg::DEPTH_W-1:0]    depth_now,
  output logic [ehash_pkg::BUSED_W-1:0]    buckets_used,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ehash_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ehash_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ehash_pkg::*;

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic          q_full, q_empty, q_push, q_pop, clearing;
  logic [KW+1:0] q_in, q_head;

  assign cfg_ready = 1'b1;

  ehash_front #(.KW(KW)) u_front (
    .item_valid, .item_stall, .cmd, .key,
    .q_full, .clearing, .push(q_push), .push_data(q_in)
  );

  ehash_queue #(.W(KW + 2)) u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .pop(q_pop),
    .head(q_head), .empty(q_empty), .full(q_full)
  );

  ehash_back #(
    .MAX_DEPTH(MAX_DEPTH), .MAX_CAPACITY(MAX_CAPACITY), .KW(KW)
  ) u_back (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .q_head, .q_empty, .q_pop, .clearing,
    .result_valid, .result_stall, .status, .depth_now, .buckets_used
  );

endmodule
